@@ hw/rtl/clt_pkg.sv @@
package clt_pkg;

    // Character codes that the classifier recognises.
    localparam logic [7:0] CHR_NUL     = 8'h00;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_BANG    = 8'h21;
    localparam logic [7:0] CHR_DQUOTE  = 8'h22;
    localparam logic [7:0] CHR_HASH    = 8'h23;

    // Saturation limits of the line counters.
    localparam logic [7:0]  TOKEN_MAX = 8'hFF;
    localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

    // Error codes reported with the end of a line.
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_QUOTE_IN_WORD = 2'd1;
    localparam logic [1:0] ERR_OPEN_QUOTE   = 2'd2;

    // Byte classes produced by the front end.
    typedef enum logic [2:0] {
        CLS_BLANK,
        CLS_EOL,
        CLS_COMMENT,
        CLS_QUOTE,
        CLS_OTHER
    } clt_class_t;

    // A classified byte, as it travels from the front end to the scanner.
    typedef struct packed {
        logic [7:0] data;
        clt_class_t cls;
    } clt_item_t;

    // One result transaction.
    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_out;
        logic        token_end;
        logic        line_done;
        logic [1:0]  error_code;
        logic [7:0]  token_total;
        logic [15:0] line_length;
    } clt_result_t;

endpackage

@@ hw/rtl/clt_fifo.sv @@
module clt_fifo
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 2
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             push,
        input  logic [WIDTH-1:0] wr_data,
        output logic             full,
        input  logic             pop,
        output logic [WIDTH-1:0] rd_data,
        output logic             empty
    );

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/clt_classify.sv @@
module clt_classify
    import clt_pkg::*;
    (
        input  logic [7:0] byte_in,
        output clt_item_t  item
    );

    // Sort each incoming byte into one of the five classes.
    always_comb
    begin
        item.data = byte_in;
        unique case (byte_in) inside
            CHR_NUL, CHR_LF, CHR_CR: item.cls = CLS_EOL;
            CHR_TAB, CHR_SPACE:      item.cls = CLS_BLANK;
            CHR_BANG, CHR_HASH:      item.cls = CLS_COMMENT;
            CHR_DQUOTE:              item.cls = CLS_QUOTE;
            default:                 item.cls = CLS_OTHER;
        endcase
    end

endmodule

@@ hw/rtl/clt_scan.sv @@
module clt_scan
    import clt_pkg::*;
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        item_avail,
        input  clt_item_t   item,
        output logic        item_take,
        input  logic        result_full,
        output logic        result_push,
        output clt_result_t result
    );

    typedef enum logic [1:0] {
        MODE_BLANK,
        MODE_WORD,
        MODE_QUOTED,
        MODE_SKIP
    } mode_t;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic        has_bytes_reg;
    logic        has_bytes_next;
    logic [1:0]  error_reg;
    logic [1:0]  error_next;
    logic [7:0]  tokens_reg;
    logic [7:0]  tokens_next;
    logic [7:0]  tokens_closed;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic        fire;
    logic        char_valid;
    logic        token_end;
    logic        line_done;

    // A byte is processed whenever one waits and the result queue has room.
    assign fire        = item_avail && !result_full;
    assign item_take   = fire;
    assign result_push = fire;

    // Counter values when the current token closes.
    assign tokens_closed = (has_bytes_reg && tokens_reg != TOKEN_MAX) ?
                           tokens_reg + 1'b1 : tokens_reg;
    assign length_next   = (length_reg != LENGTH_MAX) ? length_reg + 1'b1 : length_reg;

    // Scanner transition for one classified byte.
    always_comb
    begin
        mode_next      = mode_reg;
        has_bytes_next = has_bytes_reg;
        error_next     = error_reg;
        tokens_next    = tokens_reg;
        char_valid     = 1'b0;
        token_end      = 1'b0;
        line_done      = 1'b0;
        unique case (mode_reg)
            MODE_SKIP:
            begin
                line_done = (item.cls == CLS_EOL);
            end
            MODE_BLANK:
            begin
                case (item.cls)
                    CLS_COMMENT: mode_next = MODE_SKIP;
                    CLS_EOL:     line_done = 1'b1;
                    CLS_QUOTE:   mode_next = MODE_QUOTED;
                    CLS_OTHER:
                    begin
                        char_valid     = 1'b1;
                        has_bytes_next = 1'b1;
                        mode_next      = MODE_WORD;
                    end
                    default:     mode_next = MODE_BLANK;
                endcase
            end
            MODE_WORD:
            begin
                case (item.cls) inside
                    CLS_BLANK, CLS_EOL, CLS_COMMENT:
                    begin
                        token_end      = has_bytes_reg;
                        tokens_next    = tokens_closed;
                        has_bytes_next = 1'b0;
                        line_done      = (item.cls == CLS_EOL);
                        if (item.cls == CLS_BLANK)
                        begin
                            mode_next = MODE_BLANK;
                        end
                        else if (item.cls == CLS_COMMENT)
                        begin
                            mode_next = MODE_SKIP;
                        end
                    end
                    CLS_QUOTE:
                    begin
                        // The partial word is dropped and the line skipped.
                        error_next     = ERR_QUOTE_IN_WORD;
                        has_bytes_next = 1'b0;
                        mode_next      = MODE_SKIP;
                    end
                    default:
                    begin
                        char_valid     = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                endcase
            end
            MODE_QUOTED:
            begin
                case (item.cls)
                    CLS_EOL:
                    begin
                        error_next     = ERR_OPEN_QUOTE;
                        has_bytes_next = 1'b0;
                        line_done      = 1'b1;
                    end
                    CLS_QUOTE:
                    begin
                        // An empty quoted string closes without a token.
                        token_end      = has_bytes_reg;
                        tokens_next    = tokens_closed;
                        has_bytes_next = 1'b0;
                        mode_next      = MODE_BLANK;
                    end
                    default:
                    begin
                        char_valid     = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                mode_next = MODE_BLANK;
            end
        endcase
    end

    // Result transaction carries the running values after this byte.
    always_comb
    begin
        result.char_valid  = char_valid;
        result.char_out    = char_valid ? item.data : 8'h00;
        result.token_end   = token_end;
        result.line_done   = line_done;
        result.error_code  = error_next;
        result.token_total = tokens_next;
        result.line_length = length_next;
    end

    // Line state; the end of a line returns everything to its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_BLANK;
            has_bytes_reg <= 1'b0;
            error_reg     <= ERR_NONE;
            tokens_reg    <= '0;
            length_reg    <= '0;
        end
        else if (fire)
        begin
            if (line_done)
            begin
                mode_reg      <= MODE_BLANK;
                has_bytes_reg <= 1'b0;
                error_reg     <= ERR_NONE;
                tokens_reg    <= '0;
                length_reg    <= '0;
            end
            else
            begin
                mode_reg      <= mode_next;
                has_bytes_reg <= has_bytes_next;
                error_reg     <= error_next;
                tokens_reg    <= tokens_next;
                length_reg    <= length_next;
            end
        end
    end

endmodule

@@ hw/rtl/command_line_tokenizer_top.sv @@
// Command line tokenizer. Bytes are pushed in one per transaction and each
// one yields exactly one result transaction, in order. Bytes are classified
// on entry and held in a short queue; while a byte waits there and the small
// output queue has room, a scanner takes one byte per clock from the first
// queue and writes its result into the output queue, the rate set by the
// scanner state update. Each byte is registered in the input queue and its
// result in the output queue. Error code, token count and line length are
// final on the result with line_done set; the next byte starts a fresh line.
module command_line_tokenizer_top
    import clt_pkg::*;
    #(
        parameter int MID_DEPTH = 4,
        parameter int OUT_DEPTH = 2
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        push,
        output logic        full,
        input  logic [7:0]  byte_in,
        output logic        empty,
        input  logic        pop,
        output logic        char_valid,
        output logic [7:0]  char_out,
        output logic        token_end,
        output logic        line_done,
        output logic [1:0]  error_code,
        output logic [7:0]  token_total,
        output logic [15:0] line_length
    );

    localparam int ITEM_W   = $bits(clt_item_t);
    localparam int RESULT_W = $bits(clt_result_t);

    clt_item_t   front_item;
    clt_item_t   scan_item;
    logic        mid_empty;
    logic        scan_take;
    logic        out_full;
    logic        scan_push;
    clt_result_t scan_result;
    clt_result_t head_result;

    // Front end: classification of the incoming byte.
    clt_classify u_classify
    (
        .byte_in (byte_in),
        .item    (front_item)
    );

    // Queue between classifier and scanner.
    clt_fifo
    #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    )
    u_mid_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_item),
        .full    (full),
        .pop     (scan_take),
        .rd_data (scan_item),
        .empty   (mid_empty)
    );

    // Back end: the token scanner.
    clt_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_avail  (!mid_empty),
        .item        (scan_item),
        .item_take   (scan_take),
        .result_full (out_full),
        .result_push (scan_push),
        .result      (scan_result)
    );

    // Result queue towards the consumer.
    clt_fifo
    #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    )
    u_out_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (scan_push),
        .wr_data (scan_result),
        .full    (out_full),
        .pop     (pop),
        .rd_data (head_result),
        .empty   (empty)
    );

    assign char_valid  = head_result.char_valid;
    assign char_out    = head_result.char_out;
    assign token_end   = head_result.token_end;
    assign line_done   = head_result.line_done;
    assign error_code  = head_result.error_code;
    assign token_total = head_result.token_total;
    assign line_length = head_result.line_length;

endmodule

@@ hw/rtl/clt_checker.sv @@
module clt_checker
    import clt_pkg::*;
    (
        input logic        clk,
        input logic        rst_n,
        input logic        push,
        input logic        full,
        input logic [7:0]  byte_in,
        input logic        empty,
        input logic        pop,
        input logic        char_valid,
        input logic [7:0]  char_out,
        input logic        token_end,
        input logic        line_done,
        input logic [1:0]  error_code,
        input logic [7:0]  token_total,
        input logic [15:0] line_length
    );

    // A token byte never coincides with a token close or a line end.
    a_char_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && char_valid |-> !token_end && !line_done)
        else $error("token byte shown together with token or line end");

    // Stripped or non-token bytes read as zero.
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !char_valid |-> char_out == 8'h00)
        else $error("char_out not zero without char_valid");

    // An open quote is only ever reported at the end of its line.
    a_open_quote: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && error_code == ERR_OPEN_QUOTE |-> line_done)
        else $error("open quote error before end of line");

    // Every result counts at least the byte that caused it.
    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> line_length != 16'h0000)
        else $error("result with zero line length");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(char_out) && $stable(line_length)
            && $stable(token_total) && $stable(line_done))
        else $error("waiting result changed before pop");

endmodule

bind command_line_tokenizer_top clt_checker u_clt_checker (.*);

@@ dv/command_line_tokenizer_checker.sv @@
`timescale 1ns / 100ps

module command_line_tokenizer_checker
    import clt_pkg::*;
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        push,
        input  logic        full,
        input  logic [7:0]  byte_in,
        input  logic        empty,
        input  logic        pop,
        input  logic        char_valid,
        input  logic [7:0]  char_out,
        input  logic        token_end,
        input  logic        line_done,
        input  logic [1:0]  error_code,
        input  logic [7:0]  token_total,
        input  logic [15:0] line_length,
        output int          mismatch_count,
        output int          results_pending
    );

    // Scanner states, as the line is walked byte by byte.
    typedef enum logic [1:0] {
        SCAN_BLANK,
        SCAN_WORD,
        SCAN_QUOTED,
        SCAN_SKIP
    } scan_mode_t;

    scan_mode_t  mode;
    logic        in_token;
    logic [1:0]  line_err;
    logic [7:0]  tokens_done;
    logic [15:0] bytes_seen;
    int          fails = 0;

    // Results predicted for accepted bytes, oldest first.
    clt_result_t predicted_results[$];

    assign mismatch_count = fails;

    // Returns the scanner state to the start of a fresh line.
    function automatic void clear_line();
        mode        = SCAN_BLANK;
        in_token    = 1'b0;
        line_err    = ERR_NONE;
        tokens_done = '0;
        bytes_seen  = '0;
    endfunction

    function automatic clt_class_t class_of(input logic [7:0] b);
        if (b == CHR_NUL || b == CHR_LF || b == CHR_CR)
            return CLS_EOL;
        if (b == CHR_TAB || b == CHR_SPACE)
            return CLS_BLANK;
        if (b == CHR_BANG || b == CHR_HASH)
            return CLS_COMMENT;
        if (b == CHR_DQUOTE)
            return CLS_QUOTE;
        return CLS_OTHER;
    endfunction

    // Closes the current token; an empty one is not counted.
    function automatic logic close_token();
        if (!in_token)
            return 1'b0;
        in_token = 1'b0;
        if (tokens_done != TOKEN_MAX)
            tokens_done = tokens_done + 8'd1;
        return 1'b1;
    endfunction

    // Works out the result of one byte and advances the line state.
    function automatic clt_result_t tokenize_byte(input logic [7:0] b);
        clt_result_t r;
        clt_class_t  c;
        r = '0;
        c = class_of(b);
        if (bytes_seen != LENGTH_MAX)
            bytes_seen = bytes_seen + 16'd1;
        case (mode)
            SCAN_SKIP:
            begin
                if (c == CLS_EOL)
                    r.line_done = 1'b1;
            end
            SCAN_BLANK:
            begin
                if (c == CLS_COMMENT)
                    mode = SCAN_SKIP;
                else if (c == CLS_EOL)
                    r.line_done = 1'b1;
                else if (c == CLS_QUOTE)
                    mode = SCAN_QUOTED;
                else if (c == CLS_OTHER)
                begin
                    r.char_valid = 1'b1;
                    in_token     = 1'b1;
                    mode         = SCAN_WORD;
                end
            end
            SCAN_WORD:
            begin
                if (c == CLS_BLANK)
                begin
                    r.token_end = close_token();
                    mode        = SCAN_BLANK;
                end
                else if (c == CLS_EOL)
                begin
                    r.token_end = close_token();
                    r.line_done = 1'b1;
                end
                else if (c == CLS_COMMENT)
                begin
                    r.token_end = close_token();
                    mode        = SCAN_SKIP;
                end
                else if (c == CLS_QUOTE)
                begin
                    // A quote inside a word drops the word and skips the line.
                    line_err = ERR_QUOTE_IN_WORD;
                    in_token = 1'b0;
                    mode     = SCAN_SKIP;
                end
                else
                begin
                    r.char_valid = 1'b1;
                    in_token     = 1'b1;
                end
            end
            default:
            begin
                if (c == CLS_EOL)
                begin
                    line_err    = ERR_OPEN_QUOTE;
                    in_token    = 1'b0;
                    r.line_done = 1'b1;
                end
                else if (c == CLS_QUOTE)
                begin
                    r.token_end = close_token();
                    mode        = SCAN_BLANK;
                end
                else
                begin
                    r.char_valid = 1'b1;
                    in_token     = 1'b1;
                end
            end
        endcase
        r.char_out    = r.char_valid ? b : 8'h00;
        r.error_code  = line_err;
        r.token_total = tokens_done;
        r.line_length = bytes_seen;
        if (r.line_done)
            clear_line();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    // Each result transaction is compared with the oldest prediction; each
    // accepted byte adds a prediction.
    always @(posedge clk or negedge rst_n)
    begin
        clt_result_t want;
        if (!rst_n)
        begin
            clear_line();
            predicted_results.delete();
            results_pending <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fails++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("char_valid", 16'(want.char_valid), 16'(char_valid));
                    check_field("char_out", 16'(want.char_out), 16'(char_out));
                    check_field("token_end", 16'(want.token_end), 16'(token_end));
                    check_field("line_done", 16'(want.line_done), 16'(line_done));
                    check_field("error_code", 16'(want.error_code), 16'(error_code));
                    check_field("token_total", 16'(want.token_total), 16'(token_total));
                    check_field("line_length", want.line_length, line_length);
                end
            end
            if (push && !full)
                predicted_results.push_back(tokenize_byte(byte_in));
            results_pending <= predicted_results.size();
        end
    end

endmodule

@@ dv/tb_command_line_tokenizer_top.sv @@
`timescale 1ns / 100ps

module tb_command_line_tokenizer_top;
    import clt_pkg::*;

    localparam int RANDOM_ITEMS = 520;
    localparam int CALM_ITEMS   = 120;
    localparam int HOLD_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  byte_in = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        token_end;
    logic        line_done;
    logic [1:0]  error_code;
    logic [7:0]  token_total;
    logic [15:0] line_length;

    int mismatch_count;
    int results_pending;
    int items_sent = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    command_line_tokenizer_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_in     (byte_in),
        .empty       (empty),
        .pop         (pop),
        .char_valid  (char_valid),
        .char_out    (char_out),
        .token_end   (token_end),
        .line_done   (line_done),
        .error_code  (error_code),
        .token_total (token_total),
        .line_length (line_length)
    );

    command_line_tokenizer_checker token_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .byte_in         (byte_in),
        .empty           (empty),
        .pop             (pop),
        .char_valid      (char_valid),
        .char_out        (char_out),
        .token_end       (token_end),
        .line_done       (line_done),
        .error_code      (error_code),
        .token_total     (token_total),
        .line_length     (line_length),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[command_line_tokenizer_top] ERROR");
            $finish;
        end
    end

    // Byte classes used to build lines.
    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHR_NUL || b == CHR_LF || b == CHR_CR || b == CHR_TAB ||
               b == CHR_SPACE || b == CHR_BANG || b == CHR_HASH || b == CHR_DQUOTE)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] non_eol_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHR_NUL || b == CHR_LF || b == CHR_CR)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Anything that may stand inside quotes.
    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        b = non_eol_byte();
        while (b == CHR_DQUOTE)
            b = non_eol_byte();
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 1) != 0) ? CHR_TAB : CHR_SPACE;
    endfunction

    function automatic logic [7:0] comment_byte();
        return ($urandom_range(0, 1) != 0) ? CHR_BANG : CHR_HASH;
    endfunction

    function automatic logic [7:0] eol_byte();
        case ($urandom_range(0, 2))
            0: return CHR_NUL;
            1: return CHR_LF;
            default: return CHR_CR;
        endcase
    endfunction

    // Offers one byte until it is taken, then perhaps idles for a short burst.
    task automatic send_byte(input logic [7:0] b);
        push    <= 1'b1;
        byte_in <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // One line: mostly well-formed, some broken, some raw noise.
    task automatic send_random_line();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            repeat ($urandom_range(0, 2)) send_byte(blank_byte());
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte(CHR_DQUOTE);
                    repeat ($urandom_range(0, 5)) send_byte(quoted_byte());
                    send_byte(CHR_DQUOTE);
                    repeat ($urandom_range(0, 2)) send_byte(blank_byte());
                end
                else
                begin
                    repeat ($urandom_range(1, 6)) send_byte(other_byte());
                    repeat ($urandom_range(1, 2)) send_byte(blank_byte());
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_byte(comment_byte());
                repeat ($urandom_range(0, 4)) send_byte(non_eol_byte());
            end
        end
        else if (kind < 85)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                repeat ($urandom_range(1, 4)) send_byte(other_byte());
                send_byte(CHR_DQUOTE);
                repeat ($urandom_range(0, 4)) send_byte(non_eol_byte());
            end
            else
            begin
                send_byte(CHR_DQUOTE);
                repeat ($urandom_range(0, 5)) send_byte(quoted_byte());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(eol_byte());
    endtask

    // Result side: short random stalls, one long hold-off on request.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                pop   <= 1'b0;
                stall = $urandom_range(0, 2);
            end
            else
                pop <= 1'b1;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int start;
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Word, tab, quoted string with blank and comment inside, comment
        // closing a word.
        send_text("a");
        send_byte(CHR_TAB);
        send_text("\"b #\"c!x");
        send_byte(CHR_LF);
        // Empty quoted string, then a quote inside a word.
        send_text("\"\"x\"y");
        send_byte(CHR_NUL);
        // Line ending inside quotes.
        send_text("\"q");
        send_byte(CHR_CR);
        // Top-bit bytes and a bare comment.
        send_byte(8'hFF);
        send_byte(CHR_SPACE);
        send_byte(8'h80);
        send_byte(CHR_HASH);
        send_byte(CHR_LF);

        // One long line that runs the token counter into saturation.
        repeat (300)
        begin
            send_byte(other_byte());
            send_byte(blank_byte());
        end
        send_byte(comment_byte());
        repeat (8) send_byte(non_eol_byte());
        send_byte(eol_byte());
        wait_drained();

        // Random lines.
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (!held && items_sent - start > 150)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && items_sent - start > 300)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if (items_sent - start > RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_random_line();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[command_line_tokenizer_top] OK");
        else
            $display("[command_line_tokenizer_top] ERROR");
        $finish;
    end

endmodule
